FILE: rtl/core/sphere_point_to_ring_pixel_top_macros.svh
// assertion macros shared by the ring pixel block
`ifndef SPHERE_POINT_TO_RING_PIXEL_TOP_MACROS_SVH
`define SPHERE_POINT_TO_RING_PIXEL_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define SP_ASSERT(lbl, prop, msg)
`define SP_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/sp2rp_pkg.sv
// types and constants of the ring pixel block
`default_nettype none
package sp2rp_pkg;
  localparam int unsigned OrderW = 4;
  localparam int unsigned PixW = 28;
  localparam int unsigned QuotW = 31;
  localparam int unsigned RootW = 31;
  localparam int unsigned RadW = 62;
  localparam logic [OrderW-1:0] OrderRst = 4'd4;
  localparam logic [31:0] OneQ30 = 32'h4000_0000;

  typedef enum logic [1:0] {
    REG_NORTH = 2'd0,
    REG_BELT  = 2'd1,
    REG_SOUTH = 2'd2
  } region_e;

  typedef struct packed {
    region_e         region;
    logic            sine;
    logic [31:0]     az;
    logic [30:0]     sth;
    logic [PixW-1:0] pix_eq;
  } side_t;
endpackage
`default_nettype wire

FILE: rtl/core/sp2rp_front.sv
// input conditioning, region decision and equatorial pixel
`default_nettype none
module sp2rp_front
  import sp2rp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [OrderW-1:0]  order_i,
  input  logic               vld_i,
  input  logic signed [31:0] z_i,
  input  logic [31:0]        az_i,
  input  logic [30:0]        sth_i,
  input  logic               use_i,
  output logic               vld_o,
  output side_t              side_o,
  output logic [31:0]        d_o,
  output logic [31:0]        rarg_o
);
  localparam logic signed [31:0] ZMax = 32'sh4000_0000;
  localparam logic signed [31:0] ZMin = -32'sh4000_0000;

  // stage 1: saturate
  logic signed [31:0] zs_d, z1_q;
  logic [30:0] za_d, za1_q, sth_d, sth1_q;
  logic [31:0] az1_q;
  logic use1_q, vld1_q;

  always_comb begin
    if (z_i > ZMax) begin
      zs_d = ZMax;
    end else if (z_i < ZMin) begin
      zs_d = ZMin;
    end else begin
      zs_d = z_i;
    end
    za_d  = zs_d[31] ? 31'(-zs_d) : zs_d[30:0];
    sth_d = (sth_i > OneQ30[30:0]) ? OneQ30[30:0] : sth_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else if (en_i) vld1_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q   <= zs_d;
      za1_q  <= za_d;
      sth1_q <= sth_d;
      az1_q  <= az_i;
      use1_q <= use_i;
    end
  end

  // stage 2: region, edge-line sums, divider and root operands
  logic [32:0] za3;
  logic [37:0] za100;
  logic belt, near;
  logic [35:0] a36, b36, em_d, ep_d, em2_q, ep2_q;
  logic [31:0] d_d, rdiff, rarg_d, d2_q, rarg2_q;
  side_t s2_d, s2_q;
  logic vld2_q;

  always_comb begin
    za3   = {2'b0, za1_q} + {1'b0, za1_q, 1'b0};
    belt  = za3 <= 33'h0_8000_0000;
    za100 = {7'b0, za1_q} * 38'd100;
    near  = za100 >= (38'd99 << 30);
    s2_d.sine = use1_q && !belt && near;
    if (belt) s2_d.region = REG_BELT;
    else if (!z1_q[31] && (z1_q != '0)) s2_d.region = REG_NORTH;
    else s2_d.region = REG_SOUTH;
    s2_d.az     = az1_q;
    s2_d.sth    = sth1_q;
    s2_d.pix_eq = '0;
    a36   = 36'h0_8000_0000 + {2'b0, az1_q, 2'b0};
    b36   = {{4{z1_q[31]}}, z1_q} + {{3{z1_q[31]}}, z1_q, 1'b0};
    em_d  = a36 - b36;
    ep_d  = a36 + b36;
    d_d   = s2_d.sine ? ({1'b0, za1_q} + OneQ30) : 32'h8000_0000;
    rdiff = OneQ30 - {1'b0, za1_q};
    rarg_d = rdiff + {rdiff[30:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld2_q <= 1'b0;
    else if (en_i) vld2_q <= vld1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q    <= s2_d;
      em2_q   <= em_d;
      ep2_q   <= ep_d;
      d2_q    <= d_d;
      rarg2_q <= rarg_d;
    end
  end

  // stage 3: edge-line indices and ring number
  logic [5:0] sh;
  logic [19:0] jp, jm;
  logic [23:0] nside, ir_d, sum_d, ir3_q, sum3_q;
  side_t s3_q;
  logic [31:0] d3_q, rarg3_q;
  logic vld3_q;

  assign sh    = 6'd32 - {2'b0, order_i};
  assign jp    = 20'(em2_q >> sh);
  assign jm    = 20'(ep2_q >> sh);
  assign nside = 24'd1 << order_i;
  assign ir_d  = nside + 24'd1 + 24'(jp) - 24'(jm);
  assign sum_d = 24'(jp) + 24'(jm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld3_q <= 1'b0;
    else if (en_i) vld3_q <= vld2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ir3_q   <= ir_d;
      sum3_q  <= sum_d;
      s3_q    <= s2_q;
      d3_q    <= d2_q;
      rarg3_q <= rarg2_q;
    end
  end

  // stage 4: pixel within the ring and belt pixel number
  logic [23:0] kshift, t, ipm;
  logic [31:0] ncap, pixw;
  side_t s4_d, s4_q;
  logic [31:0] d4_q, rarg4_q;
  logic vld4_q;

  always_comb begin
    kshift = {23'b0, ~ir3_q[0]};
    t      = sum3_q - nside + kshift + 24'd1 + (nside << 3);
    ipm    = (t >> 1) & ((nside << 2) - 24'd1);
    ncap   = (32'd2 << {order_i, 1'b0}) - (32'd2 << order_i);
    pixw   = ncap + ((32'(ir3_q) - 32'd1) << ({1'b0, order_i} + 5'd2)) + 32'(ipm);
    s4_d   = s3_q;
    s4_d.pix_eq = pixw[PixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld4_q <= 1'b0;
    else if (en_i) vld4_q <= vld3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q    <= s4_d;
      d4_q    <= d3_q;
      rarg4_q <= rarg3_q;
    end
  end

  assign vld_o  = vld4_q;
  assign side_o = s4_q;
  assign d_o    = d4_q;
  assign rarg_o = rarg4_q;
endmodule
`default_nettype wire

FILE: rtl/core/sp2rp_div.sv
// pipelined restoring divider, one quotient bit per stage, 3*2^60 / d
`default_nettype none
module sp2rp_div
  import sp2rp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  side_t            side_i,
  input  logic [31:0]      d_i,
  input  logic [31:0]      rarg_i,
  output logic             vld_o,
  output side_t            side_o,
  output logic [QuotW-1:0] q_o,
  output logic [31:0]      rarg_o
);
  logic             vld_q  [QuotW+1];
  side_t            side_q [QuotW+1];
  logic [31:0]      d_q    [QuotW+1];
  logic [31:0]      rarg_q [QuotW+1];
  logic [32:0]      rem_q  [QuotW+1];
  logic [QuotW-1:0] quo_q  [QuotW+1];

  // top bits of the dividend 3*2^60, the rest are zero
  assign vld_q[0]  = vld_i;
  assign side_q[0] = side_i;
  assign d_q[0]    = d_i;
  assign rarg_q[0] = rarg_i;
  assign rem_q[0]  = 33'h0_6000_0000;
  assign quo_q[0]  = '0;

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [33:0] sft, dif;
    logic fit;
    assign sft = {rem_q[k], 1'b0};
    assign dif = sft - {2'b0, d_q[k]};
    assign fit = sft >= {2'b0, d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
        d_q[k+1]    <= d_q[k];
        rarg_q[k+1] <= rarg_q[k];
        rem_q[k+1]  <= fit ? dif[32:0] : sft[32:0];
        quo_q[k+1]  <= {quo_q[k][QuotW-2:0], fit};
      end
    end
  end

  assign vld_o  = vld_q[QuotW];
  assign side_o = side_q[QuotW];
  assign q_o    = quo_q[QuotW];
  assign rarg_o = rarg_q[QuotW];
endmodule
`default_nettype wire

FILE: rtl/core/sp2rp_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module sp2rp_sqrt
  import sp2rp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  side_t            side_i,
  input  logic [QuotW-1:0] q_i,
  input  logic [31:0]      rarg_i,
  output logic             vld_o,
  output side_t            side_o,
  output logic [RootW-1:0] root_o
);
  logic             vld_q  [RootW+1];
  side_t            side_q [RootW+1];
  logic [RadW-1:0]  rad_q  [RootW+1];
  logic [32:0]      rem_q  [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];

  // sine form takes q*2^30, root form 3*(1-|z|)*2^30
  assign vld_q[0]  = vld_i;
  assign side_q[0] = side_i;
  assign rad_q[0]  = side_i.sine ? {1'b0, q_i, 30'b0} : {rarg_i, 30'b0};
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [34:0] sft, trial, dif;
    logic fit;
    assign sft   = {rem_q[k], rad_q[k][RadW-1 -: 2]};
    assign trial = {2'b0, root_q[k], 2'b01};
    assign dif   = sft - trial;
    assign fit   = sft >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
        rad_q[k+1]  <= {rad_q[k][RadW-3:0], 2'b00};
        rem_q[k+1]  <= fit ? dif[32:0] : sft[32:0];
        root_q[k+1] <= {root_q[k][RootW-2:0], fit};
      end
    end
  end

  assign vld_o  = vld_q[RootW];
  assign side_o = side_q[RootW];
  assign root_o = root_q[RootW];
endmodule
`default_nettype wire

FILE: rtl/core/sp2rp_back.sv
// polar edge lines, ring and pixel in the cap, final pixel number
`default_nettype none
module sp2rp_back
  import sp2rp_pkg::*;
#(
  parameter int unsigned OrderLimit = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [OrderW-1:0] order_i,
  input  logic              vld_i,
  input  side_t             side_i,
  input  logic [RootW-1:0]  root_i,
  output logic              vld_o,
  output logic [PixW-1:0]   pix_o,
  output region_e           region_o
);
  localparam int unsigned IrW = OrderLimit + 1;
  localparam int unsigned IpW = IrW + 2;
  localparam int unsigned SqW = 2 * IrW;

  // stage 1: scale the root by the sine in the sine form, else pass the root
  logic [61:0] sprod;
  logic [RootW-1:0] s_d, s1_q;
  side_t side1_q;
  logic vld1_q;

  assign sprod = {31'b0, side_i.sth} * {31'b0, root_i};
  assign s_d   = side_i.sine ? sprod[60:30] : root_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else if (en_i) vld1_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= s_d;
      side1_q <= side_i;
    end
  end

  // stage 2: edge-line products
  logic [29:0] tp;
  logic [30:0] tc;
  logic [60:0] pa_d, pa2_q;
  logic [61:0] pb_d, pb2_q;
  side_t side2_q;
  logic vld2_q;

  assign tp   = side1_q.az[29:0];
  assign tc   = OneQ30[30:0] - {1'b0, tp};
  assign pa_d = {31'b0, tp} * {30'b0, s1_q};
  assign pb_d = {31'b0, tc} * {31'b0, s1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld2_q <= 1'b0;
    else if (en_i) vld2_q <= vld1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa2_q   <= pa_d;
      pb2_q   <= pb_d;
      side2_q <= side1_q;
    end
  end

  // stage 3: ring number, held within the cap
  logic [5:0] sh;
  logic [16:0] jp, jm;
  logic [17:0] sum;
  logic [IrW-1:0] nside, ir_d, ir3_q;
  side_t side3_q;
  logic vld3_q;

  assign sh    = 6'd60 - {2'b0, order_i};
  assign jp    = 17'(pa2_q >> sh);
  assign jm    = 17'(pb2_q >> sh);
  assign sum   = {1'b0, jp} + {1'b0, jm} + 18'd1;
  assign nside = IrW'(1) << order_i;
  assign ir_d  = (sum > 18'(nside)) ? nside : sum[IrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld3_q <= 1'b0;
    else if (en_i) vld3_q <= vld2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ir3_q   <= ir_d;
      side3_q <= side2_q;
    end
  end

  // stage 4: pixel in the ring and ring square
  logic [31+IrW:0] azir;
  logic [IpW-1:0] ip_d, ip4_q;
  logic [SqW-1:0] sq_d, sq4_q;
  logic [IrW-1:0] ir4_q;
  side_t side4_q;
  logic vld4_q;

  assign azir = {{IrW{1'b0}}, side3_q.az} * {32'b0, ir3_q};
  assign ip_d = azir[30 +: IpW];
  assign sq_d = {{IrW{1'b0}}, ir3_q} * {{IrW{1'b0}}, ir3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld4_q <= 1'b0;
    else if (en_i) vld4_q <= vld3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ip4_q   <= ip_d;
      sq4_q   <= sq_d;
      ir4_q   <= ir3_q;
      side4_q <= side3_q;
    end
  end

  // stage 5: cap offsets or belt pixel, and result register
  logic [31:0] npix, two_sq, two_ir, ipw, pixw;
  logic [PixW-1:0] pix5_q;
  region_e region5_q;
  logic vld5_q;

  always_comb begin
    npix   = 32'd12 << {order_i, 1'b0};
    two_sq = 32'(sq4_q) << 1;
    two_ir = 32'(ir4_q) << 1;
    ipw    = 32'(ip4_q);
    case (side4_q.region)
      REG_NORTH: pixw = two_sq - two_ir + ipw;
      REG_SOUTH: pixw = npix - two_sq - two_ir + ipw;
      default:   pixw = 32'(side4_q.pix_eq);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld5_q <= 1'b0;
    else if (en_i) vld5_q <= vld4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix5_q    <= pixw[PixW-1:0];
      region5_q <= side4_q.region;
    end
  end

  assign vld_o    = vld5_q;
  assign pix_o    = pix5_q;
  assign region_o = region5_q;
endmodule
`default_nettype wire

FILE: rtl/core/sphere_point_to_ring_pixel_top.sv
// ring-scheme pixel index of a sphere point, fully pipelined
// usage:
//   s_axis carries one point per request: tdata holds cos of colatitude
//   (signed q1.30), azimuth as a fraction of a turn and sine of colatitude
//   (q0.30); tuser flags the sine as valid for points very near a pole
//   m_axis returns one request per point: pixel index and region
//   cfg_we_i/cfg_wdata_i set the resolution order (nside = 2^order); the user
//   must write it only while no request is in flight, the block does not
//   enforce this; orders above ORDER_LIMIT act as ORDER_LIMIT
// throughput: one point per cycle, sustained while m_axis_tready stays high
// path from input handshake to m_axis_tvalid: 4 front stages, the 31-stage
//   divider, the 31-stage square root, 5 back stages and the output register
// reset: pipeline and output empty, resolution order 4
// stall: a result that is not taken sits in the output register while a
//   skid register takes one more; the pipeline freezes only when both are
//   full, so s_axis_tready drops once the skid register holds a result
//   and nothing is lost or repeated
`default_nettype none
`include "sphere_point_to_ring_pixel_top_macros.svh"
module sphere_point_to_ring_pixel_top
  import sp2rp_pkg::*;
#(
  parameter int unsigned ORDER_LIMIT = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [OrderW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // cos_colatitude[31:0], azimuth_turns[63:32], sin_colatitude[94:64], zero[95]
  input  logic [95:0]       s_axis_tdata,
  // use_sine[0]
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pixel_index[27:0], region[29:28], zero[31:30]
  output logic [31:0]       m_axis_tdata
);
  // resolution order register, clamped at use
  logic [OrderW-1:0] order_q, order_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) order_q <= OrderRst;
    else if (cfg_we_i) order_q <= cfg_wdata_i;
  end

  assign order_eff = (order_q > OrderW'(ORDER_LIMIT)) ? OrderW'(ORDER_LIMIT) : order_q;

  // whole pipeline advances together unless the skid register holds a result
  logic en;
  logic skid_vld_q, skid_vld_d, out_vld_q, out_vld_d;

  assign en = !skid_vld_q;
  assign s_axis_tready = en;

  logic  f_vld;
  side_t f_side;
  logic [31:0] f_d, f_rarg;

  sp2rp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .order_i (order_eff),
    .vld_i   (s_axis_tvalid && en),
    .z_i     ($signed(s_axis_tdata[31:0])),
    .az_i    (s_axis_tdata[63:32]),
    .sth_i   (s_axis_tdata[94:64]),
    .use_i   (s_axis_tuser[0]),
    .vld_o   (f_vld),
    .side_o  (f_side),
    .d_o     (f_d),
    .rarg_o  (f_rarg)
  );

  // quotient 3*2^60/(1+|z|) for the sine form
  logic  dv_vld;
  side_t dv_side;
  logic [QuotW-1:0] dv_q;
  logic [31:0] dv_rarg;

  sp2rp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .side_i (f_side),
    .d_i    (f_d),
    .rarg_i (f_rarg),
    .vld_o  (dv_vld),
    .side_o (dv_side),
    .q_o    (dv_q),
    .rarg_o (dv_rarg)
  );

  logic  sq_vld;
  side_t sq_side;
  logic [RootW-1:0] sq_root;

  sp2rp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld),
    .side_i (dv_side),
    .q_i    (dv_q),
    .rarg_i (dv_rarg),
    .vld_o  (sq_vld),
    .side_o (sq_side),
    .root_o (sq_root)
  );

  logic pipe_vld;
  logic [PixW-1:0] pipe_pix;
  region_e pipe_region;

  sp2rp_back #(
    .OrderLimit (ORDER_LIMIT)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .order_i  (order_eff),
    .vld_i    (sq_vld),
    .side_i   (sq_side),
    .root_i   (sq_root),
    .vld_o    (pipe_vld),
    .pix_o    (pipe_pix),
    .region_o (pipe_region)
  );

  // output register plus one skid entry
  logic [PixW+1:0] pipe_dat, out_dat_q, out_dat_d, skid_dat_q, skid_dat_d;
  logic take, pop;

  assign pipe_dat = {pipe_region, pipe_pix};
  assign take = pipe_vld && en;
  assign pop  = out_vld_q && m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_dat_d  = out_dat_q;
    skid_vld_d = skid_vld_q;
    skid_dat_d = skid_dat_q;
    if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_dat_d  = skid_dat_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = take;
        if (take) out_dat_d = pipe_dat;
      end
    end else if (take) begin
      skid_vld_d = 1'b1;
      skid_dat_d = pipe_dat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dat_q  <= out_dat_d;
    skid_dat_q <= skid_dat_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_dat_q};

  // bounds of the north cap and of the belt start, for checking
  logic [31:0] north_lim, ncap_lim;
  assign north_lim = (32'd2 << {order_eff, 1'b0}) + (32'd2 << order_eff);
  assign ncap_lim  = (32'd2 << {order_eff, 1'b0}) - (32'd2 << order_eff);

  `SP_ASSERT_IMP(a_skid_only_on_stall, $rose(skid_vld_q),
                 $past(out_vld_q && !m_axis_tready), "skid filled without a stalled output")
  `SP_ASSERT_IMP(a_north_in_cap, m_axis_tvalid && (m_axis_tdata[29:28] == REG_NORTH),
                 {4'b0, m_axis_tdata[27:0]} < north_lim, "north pixel beyond the cap")
  `SP_ASSERT_IMP(a_belt_after_cap, m_axis_tvalid && (m_axis_tdata[29:28] == REG_BELT) &&
                 (order_eff < 4'd13), {4'b0, m_axis_tdata[27:0]} >= ncap_lim,
                 "belt pixel inside the north cap")
endmodule
`default_nettype wire

FILE: sim/sphere_point_to_ring_pixel_top_tb.sv
// self-checking testbench of the ring pixel block: directed and random points
`default_nettype none
module sphere_point_to_ring_pixel_top_tb;
  import sp2rp_pkg::*;

  typedef struct packed {
    logic [27:0] pix;
    region_e     region;
  } ring_pix_t;

  // expected ring pixels of accepted points, oldest first
  class ring_pixel_board;
    ring_pix_t   pending_q[$];
    logic [3:0]  order = OrderRst;
    int          errors = 0;

    static function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic ring_pix_t ring_pixel(logic [95:0] d, logic sine_ok);
      int              o;
      longint          nside, npix, z, za, sth, nl4, t1v, t2v, jpe, jme, ire, t, ipe;
      longint unsigned az, tp, s, q, rt, jp, jm, ir, ip;
      ring_pix_t       r;
      o = (order > 12) ? 12 : order;
      nside = 64'sd1 <<< o;
      npix = 64'sd12 <<< (2 * o);
      z = longint'($signed(d[31:0]));
      az = longint'(d[63:32]);
      if (z > 64'sd1073741824) z = 64'sd1073741824;
      if (z < -64'sd1073741824) z = -64'sd1073741824;
      za = (z < 0) ? -z : z;
      sth = longint'(d[94:64]);
      if (sth > 64'sd1073741824) sth = 64'sd1073741824;
      if (3 * za <= 64'sd2147483648) begin
        nl4 = 4 * nside;
        t1v = (64'sd2147483648 + 4 * longint'(az)) * nside;
        t2v = 3 * z * nside;
        jpe = longint'(longint'(unsigned'(t1v - t2v)) >> 32);
        jme = longint'(longint'(unsigned'(t1v + t2v)) >> 32);
        jpe = (t1v - t2v) >>> 32;
        jme = (t1v + t2v) >>> 32;
        ire = nside + 1 + jpe - jme;
        t = jpe + jme - nside + (1 - (ire & 1)) + 1 + nl4 + nl4;
        ipe = (t >>> 1) & (nl4 - 1);
        r.pix = 28'(2 * nside * (nside - 1) + (ire - 1) * nl4 + ipe);
        r.region = REG_BELT;
      end else begin
        tp = az & 64'h3fff_ffff;
        if (sine_ok && (100 * za >= 99 * 64'sd1073741824)) begin
          q = (64'd3 << 60) / longint'(64'sd1073741824 + za);
          rt = int_sqrt(q << 30);
          s = (longint'(sth) * rt) >> 30;
        end else begin
          s = int_sqrt(longint'(3 * (64'sd1073741824 - za)) << 30);
        end
        jp = (tp * s) >> (60 - o);
        jm = (((64'd1 << 30) - tp) * s) >> (60 - o);
        ir = jp + jm + 1;
        if (ir > nside) ir = nside;
        ip = (az * ir) >> 30;
        if (z > 0) begin
          r.pix = 28'(2 * ir * (ir - 1) + ip);
          r.region = REG_NORTH;
        end else begin
          r.pix = 28'(longint'(npix) - 2 * ir * (ir + 1) + ip);
          r.region = REG_SOUTH;
        end
      end
      return r;
    endfunction

    function void note_point(logic [95:0] d, logic sine_ok);
      pending_q.insert(pending_q.size(), ring_pixel(d, sine_ok));
    endfunction

    function void check_pixel(logic [31:0] d);
      ring_pix_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[27:0] !== e.pix) begin
        $display("%0t: pixel mismatch, expected %0d, actual %0d", $time, e.pix, d[27:0]);
        errors++;
      end
      if (d[29:28] !== e.region) begin
        $display("%0t: region mismatch, expected %0d, actual %0d", $time, e.region, d[29:28]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  ring_pixel_board board = new();
  int  sent = 0;
  int  cycles = 0;
  bit  quiet = 0;     // last part of the run: no idling on either side
  bit  held = 0;      // long receiver hold-off done

  sphere_point_to_ring_pixel_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // accepted requests on both sides, sampled before the edge settles
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) board.note_point(s_axis_tdata, s_axis_tuser[0]);
    if (m_axis_tvalid && m_axis_tready) board.check_pixel(m_axis_tdata);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("sphere_point_to_ring_pixel_top_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off so the input backs up
  initial begin
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if (!held && sent >= 600) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        held = 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
  end

  // offer one point and wait for its request to be taken
  task automatic send_point(logic [31:0] z, logic [31:0] az, logic [30:0] sth, logic sine);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, sth, az, z};
    s_axis_tuser <= sine;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // change the order only with the pipeline empty
  task automatic write_order(logic [3:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.order = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_points();
    send_point(32'h4000_0000, 32'h0, 31'h0, 1'b0);            // north pole
    send_point(32'hc000_0000, 32'hffff_ffff, 31'h0, 1'b0);    // south pole
    send_point(32'h7fff_ffff, 32'h1234_5678, 31'h0, 1'b0);    // z saturates high
    send_point(32'h8000_0000, 32'h8765_4321, 31'h0, 1'b0);    // z saturates low
    send_point(32'h0, 32'h4000_0000, 31'h0, 1'b0);            // equator
    send_point(32'd715827882, 32'hc000_0000, 31'h0, 1'b0);    // belt edge
    send_point(32'd715827883, 32'h2000_0000, 31'h0, 1'b0);    // first cap value
    send_point(-32'sd715827882, 32'h9000_0000, 31'h0, 1'b0);
    send_point(-32'sd715827883, 32'h6000_0000, 31'h0, 1'b0);
    send_point(32'd1063004405, 32'h3333_3333, 31'd150000000, 1'b1); // just below sine use
    send_point(32'd1063004406, 32'h3333_3333, 31'd150000000, 1'b1); // sine used
    send_point(-32'sd1063004406, 32'hbbbb_bbbb, 31'd150000000, 1'b1);
    send_point(32'h4000_0000, 32'h5555_5555, 31'h7fff_ffff, 1'b1); // sine saturates
    send_point(32'h4000_0000, 32'hffff_ffff, 31'h4000_0000, 1'b1); // inconsistent sine
    send_point(32'hc000_0000, 32'h0, 31'h4000_0000, 1'b1);
    send_point(32'd1073000000, 32'haaaa_aaaa, 31'd40000000, 1'b0);
  endtask

  task automatic random_point();
    logic [31:0] z;
    logic [30:0] sth;
    int          k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: z = $urandom_range(0, 1431655764) - 715827882;
      3, 4, 5: begin
        z = $urandom_range(715827883, 1073741824);
        if ($urandom_range(0, 1)) z = -z;
      end
      6, 7: begin
        z = $urandom_range(1063004406, 1073741824);
        if ($urandom_range(0, 1)) z = -z;
      end
      default: z = $urandom;
    endcase
    sth = (k >= 6 && k <= 7) ? 31'($urandom_range(0, 160000000)) : 31'($urandom);
    send_point(z, $urandom, sth, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_points();                 // reset order 4
    write_order(4'd0);
    directed_points();
    write_order(4'd12);
    directed_points();
    write_order(4'd15);                // above the maximum, acts as 12
    for (int i = 0; i < 150; i++) random_point();
    write_order(4'd0);
    for (int i = 0; i < 150; i++) random_point();
    for (int p = 0; p < 4; p++) begin
      write_order(4'($urandom_range(1, 11)));
      for (int i = 0; i < 150; i++) random_point();
    end
    write_order(4'd12);
    for (int i = 0; i < 100; i++) random_point();
    quiet = 1;
    for (int i = 0; i < 150; i++) random_point();
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("sphere_point_to_ring_pixel_top_tb: done, clean");
    end else begin
      $display("sphere_point_to_ring_pixel_top_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sphere_point_to_ring_pixel_top.f
+incdir+rtl/core
rtl/core/sp2rp_pkg.sv
rtl/core/sp2rp_front.sv
rtl/core/sp2rp_div.sv
rtl/core/sp2rp_sqrt.sv
rtl/core/sp2rp_back.sv
rtl/core/sphere_point_to_ring_pixel_top.sv
sim/sphere_point_to_ring_pixel_top_tb.sv
